>>> design/uvs_pkg.sv
// shared types, constants and helper functions of the uv sphere vertex generator
package uvs_pkg;

    localparam int CNT_W       = 11;
    localparam int RAD_W       = 16;
    localparam int POS_W       = 17;
    localparam int COL_W       = 16;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 104;

    typedef logic [CFG_AW-1:0] t_cfg_addr;

    localparam t_cfg_addr CFG_RADIUS  = 2'd0;
    localparam t_cfg_addr CFG_SECTORS = 2'd1;
    localparam t_cfg_addr CFG_STACKS  = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
    localparam logic [CNT_W-1:0] SECTORS_RST = 11'd36;
    localparam logic [CNT_W-1:0] STACKS_RST  = 11'd18;

    // 2pi in q3.30, split for two narrow multipliers
    localparam int TWO_PI_HI_W = 17;
    localparam int TWO_PI_LO_W = 16;
    localparam logic [TWO_PI_HI_W-1:0] TWO_PI_HI = 17'd102943;
    localparam logic [TWO_PI_LO_W-1:0] TWO_PI_LO = 16'd46404;

    localparam longint GAIN_Q30 = 64'd652032874;

    localparam longint ATAN_Q30 [24] = '{
        843314857, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149,
        1048575, 524287, 262143, 131071, 65535,
        32767, 16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };

    function automatic longint q30_to_frac(input longint v, input int f);
        longint rnd;
        rnd = (longint'(1) << (30 - f)) >> 1;
        return (v + rnd) >>> (30 - f);
    endfunction

    function automatic longint atan_frac(input int k, input int f);
        return q30_to_frac(ATAN_Q30[k], f);
    endfunction

endpackage

>>> design/uv_sphere_vertex_generator_core.sv
// top level of the uv sphere vertex generator
// throughput: one item per cycle while the output is not stalled, set by the bit-per-stage divider and cordic pipelines
// the whole pipeline holds while a result waits at the output
// reset is synchronous active low: clears all valid bits and loads the default radius and counts
module uv_sphere_vertex_generator_core #(
    parameter int MAX_DIVISIONS = 1024,
    parameter int FRACTION_BITS = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  uvs_pkg::t_cfg_addr                  i_cfg_addr,
    input  logic [uvs_pkg::CFG_DW-1:0]          i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // stack_index, sector_index
    input  logic [uvs_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // pos_x, pos_y, pos_z, color_red, color_green, color_blue
    output logic [uvs_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);
    import uvs_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int QW   = F + 1;
    localparam int NW   = CNT_W + F + 1;
    localparam int DW   = CNT_W + 1;
    localparam int CW   = F + 2;
    localparam int LAT  = F + CORDIC_STAGES + 9;
    localparam int PYPW = RAD_W + 1 + CW;
    localparam int PYW  = RAD_W + 2;
    localparam int XYW  = 26;
    localparam int UW   = 2 * CW;
    localparam int PXPW = XYW + CW;
    localparam int XY_SH  = F - 8;
    localparam int PX_SH  = F + 8;
    localparam int COL_SH = 2 * F - 15;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] MAXD =
        CNT_W'((MAX_DIVISIONS > CNT_MAX) ? CNT_MAX : MAX_DIVISIONS);
    localparam logic [F-1:0] QUARTER = F'(longint'(1) << (F - 2));
    localparam logic signed [PYPW-1:0] PY_RND = PYPW'((longint'(1) << F) >> 1);
    localparam logic signed [PYPW-1:0] XY_RND = PYPW'((longint'(1) << XY_SH) >> 1);
    localparam logic signed [PXPW-1:0] PX_RND = PXPW'((longint'(1) << PX_SH) >> 1);
    localparam logic signed [UW:0]     COL_OFS =
        (UW+1)'((longint'(1) << (2 * F)) + ((longint'(1) << COL_SH) >> 1));
    localparam logic signed [PXPW-1:0] POS_MAX = PXPW'(65535);

    function automatic logic [COL_W-1:0] color_of(input logic signed [UW-1:0] u);
        logic signed [UW:0] v;
        v = ((UW+1)'(u) + COL_OFS) >>> COL_SH;
        if (v < 0) begin
            return '0;
        end else if (v > (UW+1)'(65535)) begin
            return '1;
        end else begin
            return COL_W'(v);
        end
    endfunction

    function automatic logic [POS_W-1:0] pos_sat(input logic signed [PXPW-1:0] v);
        if (v > POS_MAX) begin
            return POS_W'(POS_MAX);
        end else if (v < -POS_MAX) begin
            return POS_W'(-POS_MAX);
        end else begin
            return POS_W'(v);
        end
    endfunction

    logic [RAD_W-1:0] r_radius;
    logic [CNT_W-1:0] r_sectors;
    logic [CNT_W-1:0] r_stacks;
    logic [LAT-1:0]   r_vld;
    logic             en;

    logic [CNT_W-1:0] n_eff, m_eff, st_idx, se_idx;
    logic [NW-1:0]    r_div_se, r_div_st;
    logic [QW-1:0]    q_se, q_st;
    logic [F-1:0]     se_turn, st_turn;
    logic signed [CW-1:0] c_st, s_st, c_se, s_se;

    logic signed [PYPW-1:0] r_m1_py, r_m1_xy;
    logic signed [UW-1:0]   r_m1_ur, r_m1_ub;
    logic signed [CW-1:0]   r_m1_sst, r_m1_cse, r_m1_sse;
    logic signed [PYW-1:0]  r_m2_py;
    logic signed [XYW-1:0]  r_m2_xy;
    logic signed [CW-1:0]   r_m2_cse, r_m2_sse;
    logic [COL_W-1:0]       r_m2_red, r_m2_grn, r_m2_blu;
    logic signed [PXPW-1:0] r_m3_px, r_m3_pz;
    logic signed [PYW-1:0]  r_m3_py;
    logic [COL_W-1:0]       r_m3_red, r_m3_grn, r_m3_blu;
    logic [POS_W-1:0]       r_px, r_py, r_pz;
    logic [COL_W-1:0]       r_red, r_grn, r_blu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_RST;
            r_sectors <= SECTORS_RST;
            r_stacks  <= STACKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RADIUS:  r_radius  <= i_cfg_wdata;
                CFG_SECTORS: r_sectors <= i_cfg_wdata[CNT_W-1:0];
                CFG_STACKS:  r_stacks  <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // effective counts and saturated indices
    assign n_eff  = (r_sectors == '0) ? CNT_W'(1) : (r_sectors > MAXD) ? MAXD : r_sectors;
    assign m_eff  = (r_stacks == '0) ? CNT_W'(1) : (r_stacks > MAXD) ? MAXD : r_stacks;
    assign st_idx = (i_s_tdata[CNT_W-1:0] > m_eff) ? m_eff : i_s_tdata[CNT_W-1:0];
    assign se_idx = (i_s_tdata[2*CNT_W-1:CNT_W] > n_eff) ? n_eff : i_s_tdata[2*CNT_W-1:CNT_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div_se <= NW'({se_idx, {F{1'b0}}}) + NW'(n_eff >> 1);
            r_div_st <= NW'({st_idx, {F{1'b0}}}) + NW'(m_eff);
        end
    end

    uvs_div_pipe #(.NW(NW), .DW(DW), .QW(QW)) u_div_se (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_div_se),
        .i_divisor  (DW'(n_eff)),
        .o_quotient (q_se)
    );

    uvs_div_pipe #(.NW(NW), .DW(DW), .QW(QW)) u_div_st (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (r_div_st),
        .i_divisor  ({m_eff, 1'b0}),
        .o_quotient (q_st)
    );

    assign se_turn = q_se[F-1:0];
    assign st_turn = QUARTER - q_st[F-1:0];

    uvs_cordic #(.F(F), .CS(CORDIC_STAGES)) u_cordic_st (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_turn (st_turn),
        .o_cos  (c_st),
        .o_sin  (s_st)
    );

    uvs_cordic #(.F(F), .CS(CORDIC_STAGES)) u_cordic_se (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_turn (se_turn),
        .o_cos  (c_se),
        .o_sin  (s_se)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_py  <= PYPW'($signed({1'b0, r_radius})) * PYPW'(s_st);
            r_m1_xy  <= PYPW'($signed({1'b0, r_radius})) * PYPW'(c_st);
            r_m1_ur  <= UW'(c_st) * UW'(c_se);
            r_m1_ub  <= UW'(c_st) * UW'(s_se);
            r_m1_sst <= s_st;
            r_m1_cse <= c_se;
            r_m1_sse <= s_se;

            r_m2_py  <= PYW'((r_m1_py + PY_RND) >>> F);
            r_m2_xy  <= XYW'((r_m1_xy + XY_RND) >>> XY_SH);
            r_m2_cse <= r_m1_cse;
            r_m2_sse <= r_m1_sse;
            r_m2_red <= color_of(r_m1_ur);
            r_m2_grn <= color_of(UW'(r_m1_sst) <<< F);
            r_m2_blu <= color_of(r_m1_ub);

            r_m3_px  <= PXPW'(r_m2_xy) * PXPW'(r_m2_cse);
            r_m3_pz  <= PXPW'(r_m2_xy) * PXPW'(r_m2_sse);
            r_m3_py  <= r_m2_py;
            r_m3_red <= r_m2_red;
            r_m3_grn <= r_m2_grn;
            r_m3_blu <= r_m2_blu;

            r_px  <= pos_sat((r_m3_px + PX_RND) >>> PX_SH);
            r_pz  <= pos_sat((r_m3_pz + PX_RND) >>> PX_SH);
            r_py  <= pos_sat(PXPW'(r_m3_py));
            r_red <= r_m3_red;
            r_grn <= r_m3_grn;
            r_blu <= r_m3_blu;
        end
    end

    assign o_m_tdata = {5'b0, r_blu, r_grn, r_red, r_pz, r_py, r_px};

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_radius == '0) |-> (r_px == '0 && r_py == '0 && r_pz == '0))
        else $error("nonzero position with zero radius");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

>>> design/uvs_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage
module uvs_div_pipe #(
    parameter int NW = 28,
    parameter int DW = 12,
    parameter int QW = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic [QW-1:0] o_quotient
);

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW:0]   trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = DW'(i_dividend[NW-1:QW]);
            assign low_in = i_dividend[QW-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = (trial >= {1'b0, i_divisor});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DW'(trial - {1'b0, i_divisor}) : DW'(trial);
                r_low[k] <= low_in << 1;
                r_quo[k] <= {quo_in[QW-2:0], ge};
            end
        end
    end

    assign o_quotient = r_quo[QW-1];

endmodule

>>> design/uvs_cordic.sv
// pipelined rotation-mode cordic giving cosine and sine of a fraction of a turn
module uvs_cordic #(
    parameter int F  = 16,
    parameter int CS = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [F-1:0]        i_turn,
    output logic signed [F+1:0] o_cos,
    output logic signed [F+1:0] o_sin
);
    import uvs_pkg::*;

    localparam int RW  = F - 2;
    localparam int PHW = RW + TWO_PI_HI_W;
    localparam int PLW = RW + TWO_PI_LO_W;
    localparam int SW  = RW + 34;
    localparam int XW  = F + 3;
    localparam logic [SW-1:0]        Z_RND = SW'(longint'(1) << 29);
    localparam logic signed [XW-1:0] X0    = XW'(q30_to_frac(GAIN_Q30, F));
    localparam logic signed [XW-1:0] ONE   = XW'(longint'(1) << F);

    logic [1:0]      r_quad1;
    logic [PHW-1:0]  r_ph;
    logic [PLW-1:0]  r_pl;
    logic [1:0]      r_quad2;
    logic signed [XW-1:0] r_z0;
    logic [SW-1:0]   zsum;

    logic signed [XW-1:0] r_x [CS];
    logic signed [XW-1:0] r_y [CS];
    logic signed [XW-1:0] r_z [CS];
    logic [1:0]           r_qd [CS];

    logic signed [XW-1:0] c_raw, s_raw;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad1 <= i_turn[F-1:F-2];
            r_ph    <= PHW'(i_turn[RW-1:0]) * PHW'(TWO_PI_HI);
            r_pl    <= PLW'(i_turn[RW-1:0]) * PLW'(TWO_PI_LO);
        end
    end

    assign zsum = SW'({r_ph, 16'b0}) + SW'(r_pl) + Z_RND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad2 <= r_quad1;
            r_z0    <= XW'(zsum[SW-1:30]);
        end
    end

    for (genvar k = 0; k < CS; k++) begin : g_rot
        localparam logic signed [XW-1:0] ATAN_K = XW'(atan_frac(k, F));
        logic signed [XW-1:0] x_in, y_in, z_in;
        logic [1:0]           q_in;

        if (k == 0) begin : g_first
            assign x_in = X0;
            assign y_in = '0;
            assign z_in = r_z0;
            assign q_in = r_quad2;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
            assign q_in = r_qd[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qd[k] <= q_in;
                if (!z_in[XW-1]) begin
                    r_x[k] <= x_in - (y_in >>> k);
                    r_y[k] <= y_in + (x_in >>> k);
                    r_z[k] <= z_in - ATAN_K;
                end else begin
                    r_x[k] <= x_in + (y_in >>> k);
                    r_y[k] <= y_in - (x_in >>> k);
                    r_z[k] <= z_in + ATAN_K;
                end
            end
        end
    end

    always_comb begin
        case (r_qd[CS-1])
            2'd0: begin
                c_raw = r_x[CS-1];
                s_raw = r_y[CS-1];
            end
            2'd1: begin
                c_raw = -r_y[CS-1];
                s_raw = r_x[CS-1];
            end
            2'd2: begin
                c_raw = -r_x[CS-1];
                s_raw = -r_y[CS-1];
            end
            default: begin
                c_raw = r_y[CS-1];
                s_raw = -r_x[CS-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= (c_raw > ONE) ? (F+2)'(ONE) :
                     (c_raw < -ONE) ? (F+2)'(-ONE) : (F+2)'(c_raw);
            o_sin <= (s_raw > ONE) ? (F+2)'(ONE) :
                     (s_raw < -ONE) ? (F+2)'(-ONE) : (F+2)'(s_raw);
        end
    end

endmodule
